>>> src/nbtc_pkg.sv
// shared constants, types and tables for the naive bayes train/classify block
package nbtc_pkg;

  localparam int unsigned CNT_W   = 11;
  localparam int unsigned SUM_W   = 17;
  localparam int unsigned SQ_W    = 24;
  localparam int unsigned AGE_W   = 7;
  localparam int unsigned PROB_W  = 16;
  localparam int unsigned LG_W    = 22;
  localparam int unsigned SCORE_W = 40;
  localparam int unsigned DEN_W   = 47;

  localparam int unsigned MAX_SAMPLES = 1024;
  localparam logic [CNT_W:0] SAMPLE_CAP = (MAX_SAMPLES < 2047) ?
                                          (CNT_W+1)'(MAX_SAMPLES) : (CNT_W+1)'(2047);

  localparam logic [PROB_W-1:0] THRESH_RESET = 16'd32768;
  localparam logic [16:0]       LOG2E_Q16    = 17'd94548;
  localparam logic [63:0]       ZL_MAX       = 64'd1 << 36;
  localparam logic [38:0]       DIFF_LIMIT   = 39'd40 << 16;

  localparam logic [1:0] MODE_TRAIN    = 2'd0;
  localparam logic [1:0] MODE_CLASSIFY = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;

  localparam logic [2:0] LOG_SC  = 3'd0;
  localparam logic [2:0] LOG_PC  = 3'd1;
  localparam logic [2:0] LOG_NM1 = 3'd2;
  localparam logic [2:0] LOG_N   = 3'd3;
  localparam logic [2:0] LOG_DD  = 3'd4;

  typedef enum logic [4:0] {
    OP_NONE, OP_TRAIN, OP_CLEAR, OP_LATCH, OP_CHK,
    OP_MUL_A, OP_MUL_B, OP_MUL_C, OP_MUL_D, OP_MUL_E,
    OP_DIV, OP_ZL, OP_LOG_LOAD, OP_LOG_NORM, OP_LOG_SQ, OP_LOG_ACC,
    OP_SCORE, OP_DIFF, OP_POW, OP_POW_SH, OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       cls;
    logic [2:0] log_sel;
    logic [3:0] pow_idx;
  } cmd_t;

  typedef struct packed {
    logic model_bad;
    logic cls_ok;
    logic norm_done;
  } sts_t;

  typedef logic [15:0][31:0] root_tbl_t;

  // repeated square roots of one half in q32, entry i is used for exponent bit i
  function automatic root_tbl_t build_roots();
    root_tbl_t   tbl;
    logic [63:0] c;
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bv;
    int          i;
    int          b;
    c = 64'd1 << 31;
    for (i = 15; i >= 0; i--) begin
      x   = c << 32;
      res = '0;
      for (b = 31; b >= 0; b--) begin
        bv = 64'd1 << (2 * b);
        if (x >= res + bv) begin
          x   = x - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
      end
      c      = res;
      tbl[i] = c[31:0];
    end
    return tbl;
  endfunction

  localparam root_tbl_t ROOTS = build_roots();

endpackage

>>> src/naive_bayes_train_classify_core.sv
// two-class naive bayes trainer and classifier, top level
//
// an input word is taken when start is high and busy is low. mode selects
// train (counts update at that edge unless the sample cap is reached, busy
// stays low), clear (all statistics and the threshold return to reset values) or
// classify. a classify word raises busy and produces one result, shown for
// exactly one cycle with done_o high; busy stays high through that cycle.
// results must be taken when shown, nothing holds them.
// a classify word goes straight to its result when either class has fewer
// than two samples. otherwise each class with nonzero counts needs a
// 64-step restoring divide for the gaussian exponent and five logarithms
// (normalize, then 16 squarings on one 31x31 multiplier); the posterior
// needs 16 root multiply steps and a second 64-step divide.
// the threshold register is written on cfg_valid_i; cfg_ready_o is always
// high and writes are expected only while busy is low.
// reset clears all statistics and sets the threshold to one half.
module naive_bayes_train_classify_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode_i,
  input  logic                          label_i,
  input  logic                          sex_value_i,
  input  logic [1:0]                    pass_class_i,
  input  logic [nbtc_pkg::AGE_W-1:0]    age_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nbtc_pkg::PROB_W-1:0]   cfg_data_i,
  output logic                          done_o,
  output logic [nbtc_pkg::PROB_W-1:0]   prob_survive_o,
  output logic [nbtc_pkg::PROB_W-1:0]   prob_perish_o,
  output logic                          predicted_o,
  output logic                          model_invalid_o
);
  import nbtc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  nbtc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .sts_i  (sts),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  nbtc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .label_i         (label_i),
    .sex_value_i     (sex_value_i),
    .pass_class_i    (pass_class_i),
    .age_i           (age_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .sts_o           (sts),
    .prob_survive_o  (prob_survive_o),
    .prob_perish_o   (prob_perish_o),
    .predicted_o     (predicted_o),
    .model_invalid_o (model_invalid_o)
  );

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result word outside a busy period");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result word not followed by idle");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && model_invalid_o |->
      prob_survive_o == '0 && prob_perish_o == '0 && !predicted_o)
    else $error("invalid model with nonzero posteriors");
`endif

endmodule

>>> src/nbtc_ctrl.sv
// sequencing state machine for training, clearing and classification
module nbtc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        mode_i,
  input  nbtc_pkg::sts_t    sts_i,
  output logic              busy,
  output logic              done_o,
  output nbtc_pkg::cmd_t    cmd_o
);
  import nbtc_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE     = 20'd1 << 0,
    S_CHK      = 20'd1 << 1,
    S_MUL_A    = 20'd1 << 2,
    S_MUL_B    = 20'd1 << 3,
    S_MUL_C    = 20'd1 << 4,
    S_MUL_D    = 20'd1 << 5,
    S_MUL_E    = 20'd1 << 6,
    S_DIV      = 20'd1 << 7,
    S_ZL       = 20'd1 << 8,
    S_LOG_LOAD = 20'd1 << 9,
    S_LOG_NORM = 20'd1 << 10,
    S_LOG_SQ   = 20'd1 << 11,
    S_LOG_ACC  = 20'd1 << 12,
    S_SCORE    = 20'd1 << 13,
    S_DIFF     = 20'd1 << 14,
    S_POW      = 20'd1 << 15,
    S_POW_SH   = 20'd1 << 16,
    S_DIV2     = 20'd1 << 17,
    S_FIN      = 20'd1 << 18,
    S_OUT      = 20'd1 << 19
  } state_e;

  state_e     state_q, state_d;
  logic       cls_q, cls_d;
  logic [2:0] sel_q, sel_d;
  logic [5:0] cnt_q, cnt_d;
  logic       accept;

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);
  assign accept = start && !busy;

  always_comb begin
    state_d        = state_q;
    cls_d          = cls_q;
    sel_d          = sel_q;
    cnt_d          = cnt_q;
    cmd_o.op       = OP_NONE;
    cmd_o.cls      = cls_q;
    cmd_o.log_sel  = sel_q;
    cmd_o.pow_idx  = ~cnt_q[3:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_TRAIN: cmd_o.op = OP_TRAIN;
            MODE_CLEAR: cmd_o.op = OP_CLEAR;
            MODE_CLASSIFY: begin
              cmd_o.op = OP_LATCH;
              cls_d    = 1'b0;
              state_d  = sts_i.model_bad ? S_FIN : S_CHK;
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        cmd_o.op = OP_CHK;
        if (sts_i.cls_ok) begin
          state_d = S_MUL_A;
        end else if (cls_q) begin
          state_d = S_DIFF;
        end else begin
          cls_d = 1'b1;
        end
      end
      S_MUL_A: begin
        cmd_o.op = OP_MUL_A;
        state_d  = S_MUL_B;
      end
      S_MUL_B: begin
        cmd_o.op = OP_MUL_B;
        state_d  = S_MUL_C;
      end
      S_MUL_C: begin
        cmd_o.op = OP_MUL_C;
        state_d  = S_MUL_D;
      end
      S_MUL_D: begin
        cmd_o.op = OP_MUL_D;
        state_d  = S_MUL_E;
      end
      S_MUL_E: begin
        cmd_o.op = OP_MUL_E;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'd63) state_d = S_ZL;
      end
      S_ZL: begin
        cmd_o.op = OP_ZL;
        sel_d    = LOG_SC;
        state_d  = S_LOG_LOAD;
      end
      S_LOG_LOAD: begin
        cmd_o.op = OP_LOG_LOAD;
        state_d  = S_LOG_NORM;
      end
      S_LOG_NORM: begin
        cmd_o.op = OP_LOG_NORM;
        if (sts_i.norm_done) begin
          cnt_d   = '0;
          state_d = S_LOG_SQ;
        end
      end
      S_LOG_SQ: begin
        cmd_o.op = OP_LOG_SQ;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'd15) state_d = S_LOG_ACC;
      end
      S_LOG_ACC: begin
        cmd_o.op = OP_LOG_ACC;
        if (sel_q == LOG_DD) begin
          state_d = S_SCORE;
        end else begin
          sel_d   = sel_q + 3'd1;
          state_d = S_LOG_LOAD;
        end
      end
      S_SCORE: begin
        cmd_o.op = OP_SCORE;
        if (cls_q) begin
          state_d = S_DIFF;
        end else begin
          cls_d   = 1'b1;
          state_d = S_CHK;
        end
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        cnt_d    = '0;
        state_d  = S_POW;
      end
      S_POW: begin
        cmd_o.op = OP_POW;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'd15) state_d = S_POW_SH;
      end
      S_POW_SH: begin
        cmd_o.op = OP_POW_SH;
        cnt_d    = '0;
        state_d  = S_DIV2;
      end
      S_DIV2: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'd63) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = OP_FIN;
        state_d  = S_OUT;
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cls_q   <= 1'b0;
      sel_q   <= LOG_SC;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
      sel_q   <= sel_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> src/nbtc_dp.sv
// statistics registers and the arithmetic datapath for scoring
module nbtc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nbtc_pkg::cmd_t                cmd_i,
  input  logic                          label_i,
  input  logic                          sex_value_i,
  input  logic [1:0]                    pass_class_i,
  input  logic [nbtc_pkg::AGE_W-1:0]    age_i,
  input  logic                          cfg_valid_i,
  input  logic [nbtc_pkg::PROB_W-1:0]   cfg_data_i,
  output nbtc_pkg::sts_t                sts_o,
  output logic [nbtc_pkg::PROB_W-1:0]   prob_survive_o,
  output logic [nbtc_pkg::PROB_W-1:0]   prob_perish_o,
  output logic                          predicted_o,
  output logic                          model_invalid_o
);
  import nbtc_pkg::*;

  // statistics
  logic [CNT_W-1:0]  cnt_q     [2];
  logic [CNT_W-1:0]  sex_cnt_q [2][2];
  logic [CNT_W-1:0]  pcl_cnt_q [2][3];
  logic [SUM_W-1:0]  sum_q     [2];
  logic [SQ_W-1:0]   sqs_q     [2];
  logic [PROB_W-1:0] thr_q;

  // latched classify word
  logic             sex_q;
  logic [1:0]       pcl_q;
  logic [AGE_W-1:0] x_q;
  logic             inv_q;

  // scoring registers
  logic [34:0]      ns2_q;
  logic [17:0]      nx_q;
  logic [33:0]      s1sq_q;
  logic [17:0]      a_q;
  logic [34:0]      dd_q;
  logic [35:0]      sq_q;
  logic [46:0]      en_q;
  logic [DEN_W-1:0] den_q;
  logic [63:0]      quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [36:0]      zl_q;
  logic [35:0]      nrm_q;
  logic [5:0]       e_q;
  logic [30:0]      m_q;
  logic [15:0]      frac_q;
  logic [23:0]      lsum_q;
  logic signed [24:0]        htmp_q;
  logic signed [SCORE_W-1:0] score_q [2];
  logic             cvalid_q [2];
  logic             dpos_q;
  logic [38:0]      ad_q;
  logic [32:0]      w_q;

  logic [PROB_W-1:0] ps_q, pp_q;
  logic              pred_q, inv_out_q;

  // class operands
  logic [CNT_W-1:0] n_w, nm1_w, sc_w, pc_w;
  logic [SUM_W-1:0] s1_w;
  logic [SQ_W-1:0]  s2_w;
  logic [45:0]      nd_w;
  logic [CNT_W:0]   total_w;
  logic [13:0]      age_sq_w;
  logic [47:0]      div_t_w;
  logic             div_ge_w;
  logic [DEN_W-1:0] rem_n_w;
  logic [35:0]      lg_src_w;
  logic [LG_W-1:0]  lg_w;
  logic [61:0]      mprod_w;
  logic [31:0]      sq_p_w;
  logic signed [24:0] hneg_w, half_w;
  logic signed [SCORE_W-1:0] score_w, d_w, dabs_w;
  logic [64:0]      pw_prod_w;
  logic [32:0]      ws_w;
  logic [16:0]      small_w, ps17_w, pp17_w;
  logic [PROB_W-1:0] ps_sat_w, pp_sat_w;

  assign n_w      = cnt_q[cmd_i.cls];
  assign nm1_w    = n_w - CNT_W'(1);
  assign sc_w     = sex_cnt_q[cmd_i.cls][sex_q];
  assign pc_w     = (pcl_q == 2'd0) ? '0 : pcl_cnt_q[cmd_i.cls][pcl_q - 2'd1];
  assign s1_w     = sum_q[cmd_i.cls];
  assign s2_w     = sqs_q[cmd_i.cls];
  assign nd_w     = n_w * dd_q;
  assign total_w  = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
  assign age_sq_w = age_i * age_i;

  assign sts_o.model_bad = (cnt_q[0] < CNT_W'(2)) || (cnt_q[1] < CNT_W'(2));
  assign sts_o.cls_ok    = (sc_w != '0) && (pc_w != '0);
  assign sts_o.norm_done = nrm_q[35];

  // restoring divider, one quotient bit a step
  assign div_t_w  = {rem_q, quo_q[63]};
  assign div_ge_w = div_t_w >= {1'b0, den_q};
  assign rem_n_w  = div_ge_w ? DEN_W'(div_t_w - {1'b0, den_q}) : div_t_w[DEN_W-1:0];

  always_comb begin
    unique case (cmd_i.log_sel)
      LOG_SC:  lg_src_w = 36'(sc_w);
      LOG_PC:  lg_src_w = 36'(pc_w);
      LOG_NM1: lg_src_w = 36'(nm1_w);
      LOG_N:   lg_src_w = 36'(n_w);
      LOG_DD:  lg_src_w = {1'b0, dd_q};
      default: lg_src_w = '0;
    endcase
  end

  assign lg_w    = {e_q, frac_q};
  assign mprod_w = m_q * m_q;
  assign sq_p_w  = mprod_w[61:30];

  // halve toward zero
  assign hneg_w  = -htmp_q;
  assign half_w  = htmp_q[24] ? -(hneg_w >>> 1) : (htmp_q >>> 1);
  assign score_w = $signed({16'd0, lsum_q}) + SCORE_W'(half_w) - $signed({3'd0, zl_q});

  assign d_w    = score_q[0] - score_q[1];
  assign dabs_w = d_w[SCORE_W-1] ? -d_w : d_w;

  assign pw_prod_w = w_q * ROOTS[cmd_i.pow_idx];
  assign ws_w      = (ad_q >= DIFF_LIMIT) ? '0 : (w_q >> ad_q[21:16]);

  assign small_w = quo_q[16:0];

  always_comb begin
    if (!cvalid_q[0] && !cvalid_q[1]) begin
      ps17_w = 17'h08000;
      pp17_w = 17'h08000;
    end else if (!cvalid_q[0]) begin
      ps17_w = 17'h10000;
      pp17_w = '0;
    end else if (!cvalid_q[1]) begin
      ps17_w = '0;
      pp17_w = 17'h10000;
    end else if (dpos_q) begin
      ps17_w = small_w;
      pp17_w = 17'h10000 - small_w;
    end else begin
      pp17_w = small_w;
      ps17_w = 17'h10000 - small_w;
    end
  end

  assign ps_sat_w = ps17_w[16] ? '1 : ps17_w[15:0];
  assign pp_sat_w = pp17_w[16] ? '1 : pp17_w[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        cnt_q[c] <= '0;
        sum_q[c] <= '0;
        sqs_q[c] <= '0;
        for (int v = 0; v < 2; v++) sex_cnt_q[c][v] <= '0;
        for (int v = 0; v < 3; v++) pcl_cnt_q[c][v] <= '0;
      end
    end else if (cmd_i.op == OP_CLEAR) begin
      for (int c = 0; c < 2; c++) begin
        cnt_q[c] <= '0;
        sum_q[c] <= '0;
        sqs_q[c] <= '0;
        for (int v = 0; v < 2; v++) sex_cnt_q[c][v] <= '0;
        for (int v = 0; v < 3; v++) pcl_cnt_q[c][v] <= '0;
      end
    end else if (cmd_i.op == OP_TRAIN && total_w < SAMPLE_CAP) begin
      for (int c = 0; c < 2; c++) begin
        if (label_i == c[0]) begin
          cnt_q[c] <= cnt_q[c] + CNT_W'(1);
          sum_q[c] <= sum_q[c] + SUM_W'(age_i);
          sqs_q[c] <= sqs_q[c] + SQ_W'(age_sq_w);
          for (int v = 0; v < 2; v++) begin
            if (sex_value_i == v[0]) sex_cnt_q[c][v] <= sex_cnt_q[c][v] + CNT_W'(1);
          end
          for (int v = 0; v < 3; v++) begin
            if (pass_class_i == 2'(v + 1)) begin
              pcl_cnt_q[c][v] <= pcl_cnt_q[c][v] + CNT_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end else if (cmd_i.op == OP_CLEAR) begin
      thr_q <= THRESH_RESET;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: begin
        sex_q <= sex_value_i;
        pcl_q <= pass_class_i;
        x_q   <= age_i;
        inv_q <= sts_o.model_bad;
      end
      OP_CHK: cvalid_q[cmd_i.cls] <= sts_o.cls_ok;
      OP_MUL_A: begin
        ns2_q <= n_w * s2_w;
        nx_q  <= n_w * x_q;
      end
      OP_MUL_B: begin
        s1sq_q <= s1_w * s1_w;
        a_q    <= (nx_q >= {1'b0, s1_w}) ? nx_q - {1'b0, s1_w} : {1'b0, s1_w} - nx_q;
      end
      OP_MUL_C: begin
        dd_q <= (ns2_q > {1'b0, s1sq_q}) ? ns2_q - {1'b0, s1sq_q} : 35'd1;
        sq_q <= a_q * a_q;
      end
      OP_MUL_D: begin
        en_q  <= sq_q * nm1_w;
        den_q <= {nd_w, 1'b0};
      end
      OP_MUL_E: begin
        quo_q <= en_q * LOG2E_Q16;
        rem_q <= '0;
      end
      OP_DIV: begin
        rem_q <= rem_n_w;
        quo_q <= {quo_q[62:0], div_ge_w};
      end
      OP_ZL: begin
        zl_q   <= (quo_q > ZL_MAX) ? ZL_MAX[36:0] : quo_q[36:0];
        lsum_q <= '0;
        htmp_q <= '0;
      end
      OP_LOG_LOAD: begin
        nrm_q <= lg_src_w;
        e_q   <= 6'd35;
      end
      OP_LOG_NORM: begin
        if (nrm_q[35]) begin
          m_q    <= nrm_q[35:5];
          frac_q <= '0;
        end else if (nrm_q[35:32] == 4'd0) begin
          nrm_q <= nrm_q << 4;
          e_q   <= e_q - 6'd4;
        end else begin
          nrm_q <= nrm_q << 1;
          e_q   <= e_q - 6'd1;
        end
      end
      OP_LOG_SQ: begin
        m_q    <= sq_p_w[31] ? sq_p_w[31:1] : sq_p_w[30:0];
        frac_q <= {frac_q[14:0], sq_p_w[31]};
      end
      OP_LOG_ACC: begin
        unique case (cmd_i.log_sel)
          LOG_SC, LOG_PC: lsum_q <= lsum_q + 24'(lg_w);
          LOG_NM1:        htmp_q <= htmp_q + $signed({3'd0, lg_w});
          LOG_N, LOG_DD:  htmp_q <= htmp_q - $signed({3'd0, lg_w});
          default: ;
        endcase
      end
      OP_SCORE: score_q[cmd_i.cls] <= score_w;
      OP_DIFF: begin
        dpos_q <= !d_w[SCORE_W-1];
        ad_q   <= dabs_w[38:0];
        w_q    <= 33'h1_0000_0000;
      end
      OP_POW: begin
        if (ad_q[15:0][cmd_i.pow_idx]) w_q <= pw_prod_w[64:32];
      end
      OP_POW_SH: begin
        quo_q <= {15'd0, ws_w, 16'd0};
        den_q <= DEN_W'(34'h1_0000_0000) + DEN_W'(ws_w);
        rem_q <= '0;
      end
      OP_FIN: begin
        if (inv_q) begin
          ps_q      <= '0;
          pp_q      <= '0;
          pred_q    <= 1'b0;
          inv_out_q <= 1'b1;
        end else begin
          ps_q      <= ps_sat_w;
          pp_q      <= pp_sat_w;
          pred_q    <= (ps_sat_w >= thr_q);
          inv_out_q <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign prob_survive_o  = ps_q;
  assign prob_perish_o   = pp_q;
  assign predicted_o     = pred_q;
  assign model_invalid_o = inv_out_q;

endmodule
